// File: rtl/rhwf_pkg.sv
// ----------------------------------------------------------------------------
// rhwf_pkg
// shared types, codes and neighbor helpers for the right-hand wall follower
// ----------------------------------------------------------------------------
package rhwf_pkg;

    // input transaction: a cell load or a walk start
    typedef struct packed {
        logic       req_type;
        logic [3:0] row;
        logic [3:0] col;
        logic [7:0] tile;
    } t_req;

    // result transaction: one per walk
    typedef struct packed {
        logic [3:0]  final_row;
        logic [3:0]  final_col;
        logic [1:0]  final_heading;
        logic [15:0] pass_count;
        logic        status;
    } t_res;

    // request codes
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_START = 1'b1;

    // tile byte that marks an open cell
    localparam logic [7:0] TILE_OPEN = 8'h20;

    // heading codes
    localparam logic [1:0] HEAD_UP    = 2'd0;
    localparam logic [1:0] HEAD_LEFT  = 2'd1;
    localparam logic [1:0] HEAD_DOWN  = 2'd2;
    localparam logic [1:0] HEAD_RIGHT = 2'd3;

    // walk status codes
    localparam logic STAT_EXIT  = 1'b0;
    localparam logic STAT_LIMIT = 1'b1;

    // register map, index taken from paddr[4:2]
    localparam int CFG_AW = 5;
    localparam logic [2:0] REG_ENTRY_ROW  = 3'd0;
    localparam logic [2:0] REG_ENTRY_COL  = 3'd1;
    localparam logic [2:0] REG_EXIT_ROW   = 3'd2;
    localparam logic [2:0] REG_EXIT_COL   = 3'd3;
    localparam logic [2:0] REG_STEP_LIMIT = 3'd4;

    // neighbor coordinate width: -1 wraps to all ones, well above any grid size
    localparam int NW = 7;

    // controller to datapath commands
    typedef struct packed {
        logic clr;
        logic load_wr;
        logic start;
        logic rd;
        logic step;
        logic out_load;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic clr_last;
        logic at_goal;
        logic limit_hit;
    } t_sts;

    function automatic logic [NW-1:0] nb_row(input logic [3:0] r, input logic [1:0] h);
        logic [NW-1:0] x;
        begin
            x = {3'b000, r};
            case (h)
                HEAD_UP:   nb_row = x - NW'(1);
                HEAD_DOWN: nb_row = x + NW'(1);
                default:   nb_row = x;
            endcase
        end
    endfunction

    function automatic logic [NW-1:0] nb_col(input logic [3:0] c, input logic [1:0] h);
        logic [NW-1:0] x;
        begin
            x = {3'b000, c};
            case (h)
                HEAD_LEFT:  nb_col = x - NW'(1);
                HEAD_RIGHT: nb_col = x + NW'(1);
                default:    nb_col = x;
            endcase
        end
    endfunction

endpackage

// File: rtl/right_hand_wall_follower.sv
// ----------------------------------------------------------------------------
// right_hand_wall_follower
// maze walker: loads a grid of open cells and runs the right-hand rule
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                         payload
//  request   in         i_req_valid / o_req_stall         i_req (t_req)
//  result    out        o_res_valid / i_res_stall         o_res (t_res)
//  config    in         psel penable pwrite paddr pwdata  prdata, pready
//
//  after reset the map is swept to walls, all 2**(2*clog2(min(SIDE,16))) cells
//  (256 at SIDE 16); the request side stalls until the sweep is done
//  a load transaction writes the map without leaving idle
//  a walk runs from accept to the result register as a series of passes:
//  each pass is a map read of both neighbors, then a decide step
//  a stalled result is held while the next load or walk is already accepted
//
module right_hand_wall_follower #(
    parameter int SIDE = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request channel
    input  logic                          i_req_valid,
    output logic                          o_req_stall,
    input  rhwf_pkg::t_req                i_req,
    // result channel
    output logic                          o_res_valid,
    input  logic                          i_res_stall,
    output rhwf_pkg::t_res                o_res,
    // register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rhwf_pkg::CFG_AW-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    // configuration registers
    logic [3:0]  r_entry_row;
    logic [3:0]  r_entry_col;
    logic [3:0]  r_exit_row;
    logic [3:0]  r_exit_col;
    logic [15:0] r_step_limit;

    // result holding register
    logic           r_res_valid;
    rhwf_pkg::t_res r_res;

    rhwf_pkg::t_cmd w_cmd;
    rhwf_pkg::t_sts w_sts;
    rhwf_pkg::t_res w_res;
    logic           w_out_free;
    logic           w_cfg_wr;

    // apb write: access phase with pready tied high
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_row  <= '0;
            r_entry_col  <= '0;
            r_exit_row   <= '0;
            r_exit_col   <= '0;
            r_step_limit <= 16'hFFFF;
        end else if (w_cfg_wr) begin
            unique case (paddr[4:2])
                rhwf_pkg::REG_ENTRY_ROW:  r_entry_row  <= pwdata[3:0];
                rhwf_pkg::REG_ENTRY_COL:  r_entry_col  <= pwdata[3:0];
                rhwf_pkg::REG_EXIT_ROW:   r_exit_row   <= pwdata[3:0];
                rhwf_pkg::REG_EXIT_COL:   r_exit_col   <= pwdata[3:0];
                rhwf_pkg::REG_STEP_LIMIT: r_step_limit <= pwdata[15:0];
                default: begin
                    // unmapped address, write dropped
                end
            endcase
        end
    end

    // apb read mux
    always_comb begin
        unique case (paddr[4:2])
            rhwf_pkg::REG_ENTRY_ROW:  prdata = {28'd0, r_entry_row};
            rhwf_pkg::REG_ENTRY_COL:  prdata = {28'd0, r_entry_col};
            rhwf_pkg::REG_EXIT_ROW:   prdata = {28'd0, r_exit_row};
            rhwf_pkg::REG_EXIT_COL:   prdata = {28'd0, r_exit_col};
            rhwf_pkg::REG_STEP_LIMIT: prdata = {16'd0, r_step_limit};
            default:                  prdata = '0;
        endcase
    end

    // sequencer
    rhwf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .i_req_type  (i_req.req_type),
        .i_out_free  (w_out_free),
        .i_sts       (w_sts),
        .o_req_stall (o_req_stall),
        .o_cmd       (w_cmd)
    );

    // walker datapath with the cell map
    rhwf_dp #(
        .SIDE (SIDE)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_row        (i_req.row),
        .i_col        (i_req.col),
        .i_tile       (i_req.tile),
        .i_entry_row  (r_entry_row),
        .i_entry_col  (r_entry_col),
        .i_exit_row   (r_exit_row),
        .i_exit_col   (r_exit_col),
        .i_step_limit (r_step_limit),
        .o_res        (w_res)
    );

    // result slot is free when empty or being taken this cycle
    assign w_out_free = !r_res_valid || !i_res_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (w_cmd.out_load) begin
            r_res_valid <= 1'b1;
        end else if (!i_res_stall) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cmd.out_load) begin
            r_res <= w_res;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && i_res_stall) |-> !w_cmd.out_load)
        else $error("result transaction overwritten while stalled");

endmodule

// File: rtl/rhwf_map.sv
// ----------------------------------------------------------------------------
// rhwf_map
// open-cell bit map, one write and two registered reads, with clearing sweep
// ----------------------------------------------------------------------------
module rhwf_map #(
    parameter int AW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_clr,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic          i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr_a,
    input  logic [AW-1:0] i_raddr_b,
    output logic          o_rdata_a,
    output logic          o_rdata_b,
    output logic          o_clr_last
);

    logic          r_mem [2**AW];
    logic [AW-1:0] r_clr_addr;
    logic          r_rdata_a;
    logic          r_rdata_b;

    // sweep address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_clr) begin
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_clr) begin
            r_mem[r_clr_addr] <= 1'b0;
        end else if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a  = r_rdata_a;
    assign o_rdata_b  = r_rdata_b;
    assign o_clr_last = (r_clr_addr == {AW{1'b1}});

endmodule

// File: rtl/rhwf_dp.sv
// ----------------------------------------------------------------------------
// rhwf_dp
// walker datapath: position, heading, pass counter and the cell map
// ----------------------------------------------------------------------------
module rhwf_dp #(
    parameter int SIDE = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rhwf_pkg::t_cmd       i_cmd,
    output rhwf_pkg::t_sts       o_sts,
    input  logic [3:0]           i_row,
    input  logic [3:0]           i_col,
    input  logic [7:0]           i_tile,
    input  logic [3:0]           i_entry_row,
    input  logic [3:0]           i_entry_col,
    input  logic [3:0]           i_exit_row,
    input  logic [3:0]           i_exit_col,
    input  logic [15:0]          i_step_limit,
    output rhwf_pkg::t_res       o_res
);

    // only rows and columns below 16 can ever be loaded
    localparam int ES = (SIDE < 16) ? SIDE : 16;
    localparam int RW = $clog2(ES);
    localparam int AW = 2 * RW;
    localparam logic [rhwf_pkg::NW-1:0] ES_W = rhwf_pkg::NW'(ES);

    logic [3:0]  r_row, n_row;
    logic [3:0]  r_col, n_col;
    logic [1:0]  r_head, n_head;
    logic [15:0] r_count, n_count;

    logic [1:0]                  w_right_h;
    logic [rhwf_pkg::NW-1:0]     w_rt_row, w_rt_col, w_fw_row, w_fw_col;
    logic                        w_rt_inb, w_fw_inb, w_ld_inb;
    logic                        w_rd_rt, w_rd_fw;
    logic                        w_at_goal;

    assign w_right_h = r_head - 2'd1;
    assign w_rt_row  = rhwf_pkg::nb_row(r_row, w_right_h);
    assign w_rt_col  = rhwf_pkg::nb_col(r_col, w_right_h);
    assign w_fw_row  = rhwf_pkg::nb_row(r_row, r_head);
    assign w_fw_col  = rhwf_pkg::nb_col(r_col, r_head);
    assign w_rt_inb  = (w_rt_row < ES_W) && (w_rt_col < ES_W);
    assign w_fw_inb  = (w_fw_row < ES_W) && (w_fw_col < ES_W);
    assign w_ld_inb  = ({3'b000, i_row} < ES_W) && ({3'b000, i_col} < ES_W);

    rhwf_map #(
        .AW (AW)
    ) u_map (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clr      (i_cmd.clr),
        .i_we       (i_cmd.load_wr && w_ld_inb),
        .i_waddr    ({i_row[RW-1:0], i_col[RW-1:0]}),
        .i_wdata    (i_tile == rhwf_pkg::TILE_OPEN),
        .i_re       (i_cmd.rd),
        .i_raddr_a  ({w_rt_row[RW-1:0], w_rt_col[RW-1:0]}),
        .i_raddr_b  ({w_fw_row[RW-1:0], w_fw_col[RW-1:0]}),
        .o_rdata_a  (w_rd_rt),
        .o_rdata_b  (w_rd_fw),
        .o_clr_last (o_sts.clr_last)
    );

    // position holds between read and decide, so bounds flags stay valid
    always_comb begin
        n_row   = r_row;
        n_col   = r_col;
        n_head  = r_head;
        n_count = r_count;
        if (i_cmd.start) begin
            n_row   = i_entry_row;
            n_col   = i_entry_col;
            n_head  = rhwf_pkg::HEAD_UP;
            n_count = '0;
        end else if (i_cmd.step) begin
            if (w_rd_rt && w_rt_inb) begin
                n_head = w_right_h;
                n_row  = w_rt_row[3:0];
                n_col  = w_rt_col[3:0];
            end else if (w_rd_fw && w_fw_inb) begin
                n_row  = w_fw_row[3:0];
                n_col  = w_fw_col[3:0];
            end else begin
                n_head = r_head + 2'd1;
            end
            n_count = r_count + 16'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row   <= '0;
            r_col   <= '0;
            r_head  <= rhwf_pkg::HEAD_UP;
            r_count <= '0;
        end else begin
            r_row   <= n_row;
            r_col   <= n_col;
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    assign w_at_goal       = (r_row == i_exit_row) && (r_col == i_exit_col);
    assign o_sts.at_goal   = w_at_goal;
    assign o_sts.limit_hit = (r_count >= i_step_limit);

    assign o_res.final_row     = r_row;
    assign o_res.final_col     = r_col;
    assign o_res.final_heading = r_head;
    assign o_res.pass_count    = r_count;
    assign o_res.status        = w_at_goal ? rhwf_pkg::STAT_EXIT : rhwf_pkg::STAT_LIMIT;

    // a pass is only taken below the limit and bumps the counter by one
    a_step_below_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> !o_sts.limit_hit)
        else $error("pass taken at or past step limit");

    a_step_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |=> (r_count == $past(r_count) + 16'd1))
        else $error("pass counter did not advance by one");

endmodule

// File: rtl/rhwf_ctrl.sv
// ----------------------------------------------------------------------------
// rhwf_ctrl
// sequencer: map clear, idle intake, read/decide walk loop, result handoff
// ----------------------------------------------------------------------------
module rhwf_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    input  logic           i_req_type,
    input  logic           i_out_free,
    input  rhwf_pkg::t_sts i_sts,
    output logic           o_req_stall,
    output rhwf_pkg::t_cmd o_cmd
);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_CHECK  = 3'd2;
    localparam logic [2:0] ST_DECIDE = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    logic [2:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_req_valid) begin
                    if (i_req_type == rhwf_pkg::REQ_START) begin
                        o_cmd.start = 1'b1;
                        n_state     = ST_CHECK;
                    end else begin
                        o_cmd.load_wr = 1'b1;
                    end
                end
            end
            ST_CHECK: begin
                if (i_sts.at_goal || i_sts.limit_hit) begin
                    n_state = ST_DONE;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                o_cmd.step = 1'b1;
                n_state    = ST_CHECK;
            end
            ST_DONE: begin
                if (i_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_req_stall = (r_state != ST_IDLE);

    // the clearing sweep runs once after reset and never again
    a_clear_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_CLEAR) |=> (r_state != ST_CLEAR))
        else $error("map clear re-entered");

    a_decide_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DECIDE) |-> $past(o_cmd.rd))
        else $error("decide without a map read");

endmodule
